### rtl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types and constants of the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int unsigned POS_W = 10;
    localparam int unsigned NUM_METHODS = 7;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [0:0] KIND_PATH    = 1'b0;
    localparam logic [0:0] KIND_SUMMARY = 1'b1;

    // method words without their trailing space, first character in the low byte
    localparam logic [63:0] METHOD_WORD [NUM_METHODS] = '{
        64'("TEG"), 64'("TSOP"), 64'("TUP"), 64'("ETELED"),
        64'("HCTAP"), 64'("DAEH"), 64'("SNOITPO")
    };
    // line position of the space that ends each method word
    localparam logic [2:0] METHOD_LAST [NUM_METHODS] = '{
        3'd3, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd7
    };

    typedef struct packed {
        logic [0:0]       kind;
        logic [7:0]       pchar;
        logic [2:0]       meth;
        logic             pres;
        logic [POS_W-1:0] plen;
        logic             cut;
    } res_t;

    // results caused by one input byte, count 0 to 3
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [1:0]             cnt;
    } grp_t;

endpackage

### rtl/http_request_line_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_core
// Parses the request line of each received buffer into path bytes and a
// summary word.
//
// Input stream: one request byte per word; s_tlast marks the final byte of a
// received buffer, after which the parser starts over on a fresh line.
// Output stream: m_tuser = 0 carries one path byte, m_tuser = 1 the line
// summary (method, path present, path length, line cut). m_tlast marks the
// last word caused by one input byte. A byte may cause zero to three words.
// Path: a byte is registered in the input register, its words are formed
// from it and loaded into the result register, which drives m_tdata.
// Throughput: one byte per cycle while each byte yields at most one word and
// m_tready is high; a byte yielding several words holds the input until the
// single result register has sent them one at a time.
// Reset: parser returns to the start of a line, both registers empty.
// Stall: with m_tready low the result register holds and one more byte is
// taken into the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module http_request_line_parser_core #(
    parameter int unsigned LINE_BUFFER_SIZE = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // path_char, method_code, path_present,
                                   // path_length, line_cut, zero pad
    output logic [0:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_of_run
);
    import hrlp_pkg::*;

    grp_t grp;
    logic grp_load;
    logic grp_free;
    res_t m_res;

    hrlp_parse #(
        .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .grp_free (grp_free),
        .grp_load (grp_load),
        .grp      (grp)
    );

    hrlp_out_ser u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp_load (grp_load),
        .grp      (grp),
        .grp_free (grp_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res),
        .m_last   (m_tlast)
    );

    assign m_tuser = m_res.kind;
    assign m_tdata = {1'b0, m_res.cut, m_res.plen, m_res.pres, m_res.meth, m_res.pchar};

endmodule

### rtl/hrlp_parse.sv
// ----------------------------------------------------------------------------
// hrlp_parse
// Input register, parser state and the per-byte result logic.
// ----------------------------------------------------------------------------
module hrlp_parse #(
    parameter int unsigned LINE_BUFFER_SIZE = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          grp_free,
    output logic          grp_load,
    output hrlp_pkg::grp_t grp
);
    import hrlp_pkg::*;

    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PATH   = 3'd2;
    localparam logic [2:0] PH_AFTER  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_BUFFER_SIZE - 1);

    typedef struct packed {
        logic [2:0]             phase;
        logic [POS_W-1:0]       pos;
        logic [NUM_METHODS-1:0] cand;
        logic [POS_W-1:0]       pcount;
        logic                   held;
    } st_t;

    typedef struct packed {
        st_t  st;
        logic emit;
        res_t res;
    } step_t;

    localparam st_t ST_RESET = '{
        phase: PH_METHOD, pos: '0, cand: '1, pcount: '0, held: 1'b0
    };

    function automatic step_t end_line(st_t s, logic cut);
        step_t      r;
        logic [2:0] code;
        r    = '0;
        r.st = s;
        code = '0;
        if (s.phase != PH_METHOD) begin
            // lowest surviving candidate wins
            for (int i = NUM_METHODS - 1; i >= 0; i--) begin
                if (s.cand[i]) begin
                    code = 3'(i + 1);
                end
            end
        end
        r.emit       = 1'b1;
        r.res.kind   = KIND_SUMMARY;
        r.res.pchar  = '0;
        r.res.meth   = code;
        r.res.pres   = (s.phase != PH_METHOD);
        r.res.plen   = s.pcount;
        r.res.cut    = cut;
        r.st.phase   = PH_DONE;
        return r;
    endfunction

    function automatic step_t accept_byte(st_t s, logic [7:0] b);
        step_t            r;
        logic [POS_W-1:0] k;
        r    = '0;
        r.st = s;
        k    = s.pos;
        if (s.phase == PH_DONE) begin
            r.emit = 1'b0;
        end else if (s.pos >= POS_LIMIT) begin
            r = end_line(s, 1'b1);
        end else begin
            r.st.pos = s.pos + POS_W'(1);
            unique case (s.phase)
                PH_METHOD: begin
                    if (b == CH_SP) begin
                        for (int i = 0; i < NUM_METHODS; i++) begin
                            if (k != {{(POS_W-3){1'b0}}, METHOD_LAST[i]}) begin
                                r.st.cand[i] = 1'b0;
                            end
                        end
                        r.st.phase = PH_SKIP;
                    end else begin
                        for (int i = 0; i < NUM_METHODS; i++) begin
                            if (k >= {{(POS_W-3){1'b0}}, METHOD_LAST[i]} ||
                                METHOD_WORD[i][{k[2:0], 3'b000} +: 8] != b) begin
                                r.st.cand[i] = 1'b0;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    r.st.phase = PH_PATH;
                end
                PH_PATH: begin
                    if (b == CH_SP) begin
                        r.st.phase = PH_AFTER;
                    end else begin
                        r.emit      = 1'b1;
                        r.res.kind  = KIND_PATH;
                        r.res.pchar = b;
                        r.st.pcount = s.pcount + POS_W'(1);
                    end
                end
                default: begin
                    r.emit = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_eob_reg;
    st_t        st_reg;
    st_t        st_next;
    logic       advance;

    assign advance  = in_valid_reg && grp_free;
    assign s_tready = !in_valid_reg || grp_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        st_t        s;
        step_t      r;
        logic       second;
        logic [1:0] n;
        s      = st_reg;
        r      = '0;
        second = 1'b0;
        n      = '0;
        grp    = '0;

        if (s.phase != PH_DONE && s.held) begin
            // release the held CR, then the current byte if the line goes on
            s.held = 1'b0;
            if (in_data_reg == CH_LF) begin
                r = end_line(s, 1'b0);
            end else begin
                r = accept_byte(s, CH_CR);
                second = 1'b1;
            end
            s = r.st;
            if (r.emit) begin
                grp.res[n] = r.res;
                n = n + 2'd1;
            end
        end else if (s.phase != PH_DONE) begin
            second = 1'b1;
        end

        if (second && s.phase != PH_DONE) begin
            r.emit = 1'b0;
            if (in_data_reg == CH_LF || in_data_reg == CH_NUL) begin
                r = end_line(s, 1'b0);
                s = r.st;
            end else if (in_data_reg == CH_CR && !in_eob_reg) begin
                s.held = 1'b1;
            end else begin
                r = accept_byte(s, in_data_reg);
                s = r.st;
            end
            if (r.emit) begin
                grp.res[n] = r.res;
                n = n + 2'd1;
            end
        end

        if (in_eob_reg) begin
            if (s.phase != PH_DONE) begin
                r = end_line(s, 1'b0);
                grp.res[n] = r.res;
                n = n + 2'd1;
            end
            s = ST_RESET;
        end

        grp.cnt  = n;
        st_next  = s;
        grp_load = advance && (n != 2'd0);
    end

endmodule

### rtl/hrlp_out_ser.sv
// ----------------------------------------------------------------------------
// hrlp_out_ser
// Result register: holds the results of one byte and sends them one per word.
// ----------------------------------------------------------------------------
module hrlp_out_ser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           grp_load,
    input  hrlp_pkg::grp_t grp,
    output logic           grp_free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output hrlp_pkg::res_t m_res,
    output logic           m_last
);
    import hrlp_pkg::*;

    res_t [MAX_RESULTS-1:0] res_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             idx_reg;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_last   = (idx_reg == cnt_reg - 2'd1);
    assign m_res    = res_reg[idx_reg];
    assign grp_free = !m_tvalid || (m_tready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (grp_load) begin
            cnt_reg <= grp.cnt;
            idx_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            if (m_last) begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_load) begin
            res_reg <= grp.res;
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for http_request_line_parser_core. Request bytes go in
// as a stream. A behavioral parser inside the bench predicts the path words
// and line summaries, and a monitor compares every output word in order.
// A short table of hand-picked bytes runs first. Random requests follow:
// well-formed lines, damaged ones, noise, and a few lines at the length
// limit. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrlp_pkg::*;

    localparam int unsigned LBS          = 1024;
    localparam int unsigned IDLE_PCT     = 38;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned LIMIT        = 400000;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam int unsigned DRAIN        = 20;
    localparam int unsigned MAX_PRINTS   = 30;

    // request numbers in the random part at which special traffic starts
    localparam int unsigned REQ_HOLD     = 5;
    localparam int unsigned REQ_QUIET_LO = 8;
    localparam int unsigned REQ_QUIET_HI = 13;
    localparam int unsigned REQ_LONG_A   = 3;
    localparam int unsigned REQ_LONG_B   = 7;
    localparam int unsigned REQ_LONG_C   = 11;

    localparam logic [2:0] M_UNKNOWN = 3'd0;
    localparam logic [2:0] M_PUT     = 3'd3;

    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [71:0] PROTO_TAIL = " HTTP/1.1";

    // line terminators for the long-line requests
    localparam int unsigned TERM_NONE = 0;
    localparam int unsigned TERM_LF   = 1;
    localparam int unsigned TERM_CRLF = 2;

    typedef enum logic [2:0] {
        ST_VERB, ST_SLASH, ST_PATH, ST_TAIL, ST_DONE
    } parse_st_e;

    typedef struct packed {
        logic             kind;
        logic [7:0]       pchar;
        logic [2:0]       meth;
        logic             pres;
        logic [POS_W-1:0] plen;
        logic             cut;
        logic             last;
    } word_t;

    // one directed byte; typed rows carry the single summary word they cause
    typedef struct packed {
        logic [7:0]       data;
        logic             eob;
        logic             typed;
        logic [2:0]       meth;
        logic             pres;
        logic [POS_W-1:0] plen;
    } step_row_t;

    localparam step_row_t DIRECTED [22] = '{
        '{CH_LF,    1'b1, 1'b1, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_NUL,   1'b1, 1'b1, M_UNKNOWN, 1'b0, 10'd0},
        '{8'h50,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{8'h55,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{8'h54,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_SP,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_SLASH, 1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{8'hff,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_SP,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_CR,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_LF,    1'b1, 1'b1, M_PUT,     1'b1, 10'd1},
        // lone CR inside the verb, buffer ends on the byte after it
        '{8'h41,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_CR,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{8'h42,    1'b1, 1'b1, M_UNKNOWN, 1'b0, 10'd0},
        // space right before the terminator: empty path
        '{8'h58,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_SP,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_LF,    1'b0, 1'b1, M_UNKNOWN, 1'b1, 10'd0},
        '{CH_CR,    1'b1, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        // CR as the final byte of a buffer counts as a line byte
        '{CH_CR,    1'b1, 1'b1, M_UNKNOWN, 1'b0, 10'd0},
        '{CH_LF,    1'b0, 1'b1, M_UNKNOWN, 1'b0, 10'd0},
        '{8'h5a,    1'b0, 1'b0, M_UNKNOWN, 1'b0, 10'd0},
        '{8'h80,    1'b1, 1'b0, M_UNKNOWN, 1'b0, 10'd0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    // parser state as seen by the prediction
    parse_st_e        st;
    int unsigned      pos;
    logic [6:0]       cand;
    logic [POS_W-1:0] plen;
    logic             cr_held;

    word_t      fresh_q[$];
    word_t      due_q[$];
    logic [7:0] req_q[$];

    http_request_line_parser_core #(.LINE_BUFFER_SIZE(LBS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void restart();
        st      = ST_VERB;
        pos     = 0;
        cand    = '1;
        plen    = '0;
        cr_held = 1'b0;
    endfunction

    function automatic void emit(logic kind, logic [7:0] ch, logic [2:0] m, logic p,
                                 logic [POS_W-1:0] n, logic c);
        word_t w;
        w = '{kind, ch, m, p, n, c, 1'b0};
        fresh_q.push_back(w);
    endfunction

    function automatic void close_line(logic c);
        logic [2:0] code;
        logic       p;
        code = M_UNKNOWN;
        p = (st != ST_VERB);
        // lowest surviving candidate wins
        if (p) begin
            for (int i = NUM_METHODS - 1; i >= 0; i--) begin
                if (cand[i]) code = 3'(i + 1);
            end
        end
        emit(KIND_SUMMARY, 8'h00, code, p, plen, c);
        st = ST_DONE;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int unsigned k;
        logic [6:0]  keep;
        if (st == ST_DONE) return;
        if (pos >= LBS - 1) begin
            close_line(1'b1);
            return;
        end
        k = pos;
        pos = (pos + 1) % 1024;
        case (st)
            ST_VERB: begin
                if (b == CH_SP) begin
                    keep = '0;
                    for (int i = 0; i < NUM_METHODS; i++) begin
                        if (k == METHOD_LAST[i]) keep[i] = 1'b1;
                    end
                    cand = cand & keep;
                    st = ST_SLASH;
                end else begin
                    for (int i = 0; i < NUM_METHODS; i++) begin
                        if (k >= METHOD_LAST[i] || METHOD_WORD[i][8*k +: 8] != b)
                            cand[i] = 1'b0;
                    end
                end
            end
            ST_SLASH: st = ST_PATH;
            ST_PATH: begin
                if (b == CH_SP) begin
                    st = ST_TAIL;
                end else begin
                    emit(KIND_PATH, b, M_UNKNOWN, 1'b0, '0, 1'b0);
                    plen = plen + 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // words caused by one request byte, left in fresh_q
    function automatic void parse_byte(logic [7:0] b, logic eob);
        logic again;
        fresh_q.delete();
        again = 1'b0;
        if (st != ST_DONE && cr_held) begin
            cr_held = 1'b0;
            if (b == CH_LF) begin
                close_line(1'b0);
            end else begin
                take_byte(CH_CR);
                again = 1'b1;
            end
        end else if (st != ST_DONE) begin
            if (b == CH_LF || b == CH_NUL) close_line(1'b0);
            else if (b == CH_CR && !eob) cr_held = 1'b1;
            else take_byte(b);
        end
        // the byte after a released CR still has to be parsed
        if (again && st != ST_DONE) begin
            if (b == CH_NUL) close_line(1'b0);
            else if (b == CH_CR && !eob) cr_held = 1'b1;
            else take_byte(b);
        end
        if (eob) begin
            if (st != ST_DONE) close_line(1'b0);
            restart();
        end
        if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
    endfunction

    task automatic report(string what);
        errors++;
        if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic put_byte(logic [7:0] b, logic eob, logic typed, word_t tw);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, eob);
        if (typed) due_q.push_back(tw);
        else foreach (fresh_q[i]) due_q.push_back(fresh_q[i]);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_q.size(); i++)
            put_byte(req_q[i], i == req_q.size() - 1, 1'b0, '0);
    endtask

    task automatic make_request();
        int unsigned r;
        int unsigned m;
        int unsigned t;
        logic [7:0]  ch;
        req_q.delete();
        r = $urandom_range(99);
        if (r < 12) begin
            repeat ($urandom_range(1, 12)) req_q.push_back(8'($urandom));
            return;
        end
        m = $urandom_range(0, NUM_METHODS);
        if (m < NUM_METHODS) begin
            for (int i = 0; i < METHOD_LAST[m]; i++)
                req_q.push_back(METHOD_WORD[m][8*i +: 8]);
        end else begin
            repeat ($urandom_range(1, 8)) req_q.push_back(8'($urandom_range(8'h41, 8'h5a)));
        end
        // damage the verb now and then
        if (r < 22) req_q[$urandom_range(0, req_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        req_q.push_back(CH_SP);
        req_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : CH_SLASH);
        repeat ($urandom_range(0, 10)) begin
            t = $urandom_range(15);
            if (t == 0) ch = CH_CR;
            else if (t == 1) ch = CH_SP;
            else ch = 8'($urandom_range(8'h21, 8'hff));
            req_q.push_back(ch);
        end
        if ($urandom_range(1)) begin
            for (int i = 8; i >= 0; i--) req_q.push_back(PROTO_TAIL[8*i +: 8]);
        end
        t = $urandom_range(4);
        case (t)
            0: begin
                req_q.push_back(CH_CR);
                req_q.push_back(CH_LF);
            end
            1: req_q.push_back(CH_LF);
            2: req_q.push_back(CH_NUL);
            3: ;
            default: req_q.push_back(CH_CR);
        endcase
        // header bytes after the line
        if (t < 3) repeat ($urandom_range(0, 6)) req_q.push_back(8'($urandom));
    endtask

    task automatic make_long(int unsigned n, int unsigned term);
        req_q.delete();
        for (int i = 0; i < 3; i++) req_q.push_back(METHOD_WORD[0][8*i +: 8]);
        req_q.push_back(CH_SP);
        req_q.push_back(CH_SLASH);
        repeat (n) req_q.push_back(8'($urandom_range(8'h21, 8'hff)));
        if (term == TERM_CRLF) req_q.push_back(CH_CR);
        if (term != TERM_NONE) begin
            req_q.push_back(CH_LF);
            req_q.push_back(8'h41);
        end
    endtask

    // receiver: random backpressure, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        word_t got;
        word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tdata[7:0], m_tdata[10:8], m_tdata[11], m_tdata[21:12],
                    m_tdata[22], m_tlast};
            if (due_q.size() == 0) begin
                report($sformatf("unexpected word kind=%0d data=%h", got.kind, m_tdata));
            end else begin
                want = due_q.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.pchar != want.pchar)
                    report($sformatf("path char %h, want %h", got.pchar, want.pchar));
                if (got.meth != want.meth)
                    report($sformatf("method %0d, want %0d", got.meth, want.meth));
                if (got.pres != want.pres)
                    report($sformatf("path present %0d, want %0d", got.pres, want.pres));
                if (got.plen != want.plen)
                    report($sformatf("path length %0d, want %0d", got.plen, want.plen));
                if (got.cut != want.cut)
                    report($sformatf("line cut %0d, want %0d", got.cut, want.cut));
                if (got.last != want.last)
                    report($sformatf("last %0d, want %0d", got.last, want.last));
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        word_t       tw;
        int unsigned sent;
        int unsigned nreq;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        aresetn  = 1'b0;
        restart();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            tw = '{KIND_SUMMARY, 8'h00, DIRECTED[i].meth, DIRECTED[i].pres,
                   DIRECTED[i].plen, 1'b0, 1'b1};
            put_byte(DIRECTED[i].data, DIRECTED[i].eob, DIRECTED[i].typed, tw);
        end

        sent = 0;
        nreq = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = (nreq >= REQ_QUIET_LO && nreq < REQ_QUIET_HI);
            if (nreq == REQ_HOLD) hold_req = 1'b1;
            case (nreq)
                // exactly at the limit then CR LF, one over the limit, far over
                REQ_LONG_A: make_long(LBS - 6, TERM_CRLF);
                REQ_LONG_B: make_long(LBS - 5, TERM_LF);
                REQ_LONG_C: make_long(LBS + 6, TERM_NONE);
                default: begin
                    make_request();
                    sent += req_q.size();
                end
            endcase
            send_request();
            nreq++;
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

### files.f
rtl/hrlp_pkg.sv
rtl/hrlp_parse.sv
rtl/hrlp_out_ser.sv
rtl/http_request_line_parser_core.sv
tb/tb.sv
